@@ design/gbpg_pkg.sv @@
package gbpg_pkg;

  // config register indexes
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] REG_WIDTH  = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT = 8'd1;

  localparam int unsigned DefMaxDim = 4096;
  localparam int unsigned DimW   = 13;            // dimension register width
  localparam int unsigned CoordW = 12;            // pixel coordinate width
  localparam int unsigned TrigW  = 16;            // Q1.15
  localparam int unsigned ProdW  = TrigW + DimW + 1;
  localparam int unsigned MmW    = 2 * DimW;      // m*m
  localparam int unsigned DxW    = 24;            // signed Q8 distance
  localparam int unsigned SqW    = 2 * (DxW - 1);
  localparam int unsigned D2W    = SqW + 1;
  localparam int unsigned NumW   = D2W + 3;       // d2 * 8
  localparam int unsigned ArgW   = 24;            // Q8.16 saturated argument
  localparam int unsigned RemW   = MmW + 1;
  localparam int unsigned PhaseW = 6;
  localparam int unsigned PhaseSteps = 60;
  localparam int unsigned GeoStages = 5;
  localparam int unsigned DivStages = ArgW;
  localparam int unsigned ExpStages = 3;
  localparam int unsigned NumStages = GeoStages + DivStages + ExpStages;
  localparam logic [16:0] Log2eQ16 = 17'd94548;
  localparam logic [7:0]  FullScale = 8'd255;

  // dividend/divisor handoff into the divider
  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [ArgW-1:0] lo;
    logic [MmW-1:0]  den;
    logic            sat;
    logic            bright;
    logic            last;
  } div_in_t;

  typedef struct packed {
    logic [ArgW-1:0] arg;
    logic            bright;
    logic            last;
  } div_out_t;

  function automatic logic [TrigW-2:0] quarter_cos(input logic [3:0] r);
    logic [TrigW-2:0] v;
    case (r)
      4'd0:  v = 15'd32767;
      4'd1:  v = 15'd32587;
      4'd2:  v = 15'd32051;
      4'd3:  v = 15'd31163;
      4'd4:  v = 15'd29934;
      4'd5:  v = 15'd28377;
      4'd6:  v = 15'd26509;
      4'd7:  v = 15'd24351;
      4'd8:  v = 15'd21925;
      4'd9:  v = 15'd19260;
      4'd10: v = 15'd16384;
      4'd11: v = 15'd13328;
      4'd12: v = 15'd10126;
      4'd13: v = 15'd6813;
      4'd14: v = 15'd3425;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // k in 0..59
  function automatic logic signed [TrigW-1:0] cos_q15(input logic [PhaseW-1:0] k);
    logic [3:0] r;
    logic signed [TrigW-1:0] res;
    if (k < 6'd15) begin
      r = 4'(k);
      res = $signed({1'b0, quarter_cos(r)});
    end else if (k < 6'd30) begin
      r = 4'(6'd30 - k);
      res = -$signed({1'b0, quarter_cos(r)});
    end else if (k < 6'd45) begin
      r = 4'(k - 6'd30);
      res = -$signed({1'b0, quarter_cos(r)});
    end else begin
      r = 4'(6'd60 - k);
      res = $signed({1'b0, quarter_cos(r)});
    end
    return res;
  endfunction

  function automatic logic [16:0] pow2_neg(input logic [4:0] j);
    logic [16:0] v;
    case (j)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

@@ design/gbpg_geom.sv @@
module gbpg_geom import gbpg_pkg::*; #(
  parameter int unsigned MAX_DIM = DefMaxDim
) (
  input  logic                  clk_i,
  input  logic [GeoStages-1:0]  en_i,
  input  logic [CoordW-1:0]     px_i,
  input  logic [CoordW-1:0]     py_i,
  input  logic                  last_i,
  input  logic [PhaseW-1:0]     phase_i,
  input  logic [DimW-1:0]       width_i,
  input  logic [DimW-1:0]       height_i,
  output div_in_t               div_o
);

  localparam logic [DimW-1:0] DimCap =
    (MAX_DIM > (1 << DimW) - 1) ? DimW'((1 << DimW) - 1) : DimW'(MAX_DIM);

  logic [DimW-1:0] wd, ht;
  logic [PhaseW-1:0] k, ks;
  logic [PhaseW:0] ks_sum;

  always_comb begin
    wd = (width_i == '0) ? DimW'(1) : ((width_i > DimCap) ? DimCap : width_i);
    ht = (height_i == '0) ? DimW'(1) : ((height_i > DimCap) ? DimCap : height_i);
    k  = (phase_i >= PhaseW'(PhaseSteps)) ? phase_i - PhaseW'(PhaseSteps) : phase_i;
    ks_sum = {1'b0, k} + (PhaseW + 1)'(45);
    ks = (ks_sum >= (PhaseW + 1)'(PhaseSteps)) ?
         PhaseW'(ks_sum - (PhaseW + 1)'(PhaseSteps)) : PhaseW'(ks_sum);
  end

  // stage 0: table lookups, clamped dims, bright row
  logic [CoordW-1:0] px0_q, py0_q;
  logic last0_q, br0_q;
  logic signed [TrigW-1:0] cos0_q, sin0_q;
  logic [DimW-1:0] wd0_q, ht0_q, m0_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      px0_q  <= px_i;
      py0_q  <= py_i;
      last0_q <= last_i;
      br0_q  <= (py_i == CoordW'(ht >> 1));
      cos0_q <= cos_q15(k);
      sin0_q <= cos_q15(ks);
      wd0_q  <= wd;
      ht0_q  <= ht;
      m0_q   <= (wd < ht) ? wd : ht;
    end
  end

  // stage 1: trig * dimension, m * m
  logic [CoordW-1:0] px1_q, py1_q;
  logic last1_q, br1_q;
  logic signed [ProdW-1:0] pcx1_q, pcy1_q;
  logic [DimW-2:0] hw1_q, hh1_q;
  logic [MmW-1:0] mm1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      px1_q  <= px0_q;
      py1_q  <= py0_q;
      last1_q <= last0_q;
      br1_q  <= br0_q;
      pcx1_q <= ProdW'(cos0_q * $signed({1'b0, wd0_q}));
      pcy1_q <= ProdW'(sin0_q * $signed({1'b0, ht0_q}));
      hw1_q  <= wd0_q[DimW-1:1];
      hh1_q  <= ht0_q[DimW-1:1];
      mm1_q  <= m0_q * m0_q;
    end
  end

  // stage 2: centre in Q8 and distance
  logic signed [ProdW-1:0] offx, offy;
  logic signed [DxW-1:0] cx, cy;
  logic last2_q, br2_q;
  logic signed [DxW-1:0] dx2_q, dy2_q;
  logic [MmW-1:0] mm2_q;

  always_comb begin
    offx = (pcx1_q + ProdW'(256)) >>> 9;
    offy = (pcy1_q + ProdW'(256)) >>> 9;
    cx = $signed(DxW'({hw1_q, 8'd0})) + DxW'(offx);
    cy = $signed(DxW'({hh1_q, 8'd0})) + DxW'(offy);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      last2_q <= last1_q;
      br2_q  <= br1_q;
      dx2_q  <= $signed(DxW'({px1_q, 8'd0})) - cx;
      dy2_q  <= $signed(DxW'({py1_q, 8'd0})) - cy;
      mm2_q  <= mm1_q;
    end
  end

  // stage 3: squares
  logic [DxW-1:0] absx, absy;
  logic [DxW-2:0] ax, ay;
  logic last3_q, br3_q;
  logic [SqW-1:0] sx3_q, sy3_q;
  logic [MmW-1:0] mm3_q;

  // magnitude never reaches 2^23, top bit drops
  always_comb begin
    absx = dx2_q[DxW-1] ? DxW'(-dx2_q) : DxW'(dx2_q);
    absy = dy2_q[DxW-1] ? DxW'(-dy2_q) : DxW'(dy2_q);
    ax = absx[DxW-2:0];
    ay = absy[DxW-2:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      last3_q <= last2_q;
      br3_q  <= br2_q;
      sx3_q  <= ax * ax;
      sy3_q  <= ay * ay;
      mm3_q  <= mm2_q;
    end
  end

  // stage 4: sum, scale by 8, saturation test
  logic [NumW-1:0] num;
  logic [NumW-1:0] lim;
  div_in_t d4_q;

  always_comb begin
    num = {(D2W'(sx3_q) + D2W'(sy3_q)), 3'b000};
    lim = NumW'({mm3_q, 24'd0});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      d4_q.rem    <= RemW'(num[NumW-1:ArgW]);
      d4_q.lo     <= num[ArgW-1:0];
      d4_q.den    <= mm3_q;
      d4_q.sat    <= (num >= lim);
      d4_q.bright <= br3_q;
      d4_q.last   <= last3_q;
    end
  end

  assign div_o = d4_q;

endmodule

@@ design/gbpg_div.sv @@
module gbpg_div import gbpg_pkg::*; (
  input  logic                 clk_i,
  input  logic [DivStages-1:0] en_i,
  input  div_in_t              div_i,
  output div_out_t             div_o
);

  // one quotient bit per stage, restoring
  div_in_t         st_q [DivStages];
  logic [ArgW-1:0] quo_q [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    div_in_t         src;
    logic [ArgW-1:0] qsrc;
    logic [RemW-1:0] trial;
    logic            ge;

    if (s == 0) begin : g_first
      assign src  = div_i;
      assign qsrc = '0;
    end else begin : g_next
      assign src  = st_q[s-1];
      assign qsrc = quo_q[s-1];
    end

    always_comb begin
      trial = {src.rem[RemW-2:0], src.lo[ArgW-1]};
      ge    = (trial >= RemW'(src.den));
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        st_q[s].rem    <= ge ? trial - RemW'(src.den) : trial;
        st_q[s].lo     <= {src.lo[ArgW-2:0], 1'b0};
        st_q[s].den    <= src.den;
        st_q[s].sat    <= src.sat;
        st_q[s].bright <= src.bright;
        st_q[s].last   <= src.last;
        quo_q[s]       <= {qsrc[ArgW-2:0], ge};
      end
    end
  end

  assign div_o.arg    = st_q[DivStages-1].sat ? '1 : quo_q[DivStages-1];
  assign div_o.bright = st_q[DivStages-1].bright;
  assign div_o.last   = st_q[DivStages-1].last;

endmodule

@@ design/gbpg_exp.sv @@
module gbpg_exp import gbpg_pkg::*; (
  input  logic                 clk_i,
  input  logic [ExpStages-1:0] en_i,
  input  div_out_t             div_i,
  output logic [7:0]           value_o,
  output logic                 last_o
);

  // stage A: base-2 argument
  logic [ArgW+16:0] prod;
  logic [8:0]  ip_a_q;
  logic [15:0] fr_a_q;
  logic br_a_q, last_a_q;

  assign prod = div_i.arg * Log2eQ16;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ip_a_q   <= prod[ArgW+16:32];
      fr_a_q   <= prod[31:16];
      br_a_q   <= div_i.bright;
      last_a_q <= div_i.last;
    end
  end

  // stage B: mantissa, table plus linear interpolation
  logic [16:0] p0, p1;
  logic [23:0] interp;
  logic [16:0] mant_b_q;
  logic zero_b_q, br_b_q, last_b_q;
  logic [2:0] sh_b_q;

  always_comb begin
    p0 = pow2_neg({1'b0, fr_a_q[15:12]});
    p1 = pow2_neg(5'({1'b0, fr_a_q[15:12]}) + 5'd1);
    interp = 12'(p0 - p1) * fr_a_q[11:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      mant_b_q <= p0 - 17'(interp[23:12]);
      zero_b_q <= (ip_a_q >= 9'd8);
      sh_b_q   <= ip_a_q[2:0];
      br_b_q   <= br_a_q;
      last_b_q <= last_a_q;
    end
  end

  // stage C: scale and shift; doubles as output register
  logic [24:0] scaled;
  logic [7:0] val_q;
  logic last_q;

  assign scaled = (25'(FullScale) * 25'(mant_b_q)) >> (5'd16 + 5'(sh_b_q));

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      val_q  <= br_b_q ? FullScale : (zero_b_q ? 8'd0 : scaled[7:0]);
      last_q <= last_b_q;
    end
  end

  assign value_o = val_q;
  assign last_o  = last_q;

endmodule

@@ design/gaussian_blob_pattern_generator_unit.sv @@
// Moving Gaussian blob test-pattern source. Each pixel beat (x, y) yields
// floor(255*exp(-d2/s)) where d2 is the squared distance to a blob centre that
// circles the image middle in 60 steps; the step advances after every beat
// with tlast set. Row height/2 is always 255. The datapath is a 32-stage
// pipeline: 5 geometry stages (trig lookup, centre, squares), a 24-stage
// one-bit-per-stage divider for d2*8/(m*m), and 3 exp stages, the last being
// the output register. Throughput is one pixel per clock while the output is not
// stalled. Each stage holds its beat unless the stage after it is empty or
// moving, so bubbles close up under back-pressure and the input keeps taking
// beats while free slots remain. Width/height go through the cfg port; the user
// must write them only while the stream is idle, as the block does not enforce
// it. 0 reads as 1 and values above MAX_DIM clamp to MAX_DIM.
module gaussian_blob_pattern_generator_unit import gbpg_pkg::*; #(
  parameter int unsigned MAX_DIM = DefMaxDim
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]    cfg_data_i,
  // pixel request stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,   // [11:0] pixel_x, [23:12] pixel_y
  input  logic               s_axis_tlast,   // frame_end
  // pixel value stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,   // [7:0] intensity
  output logic               m_axis_tlast    // frame_last
);

  logic [DimW-1:0] width_q, height_q;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [NumStages-1:0] vld_q, en;
  logic s_fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(64);
      height_q <= DimW'(64);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage s may load when it is empty or its content moves on
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || m_axis_tready;
    for (int s = NumStages - 2; s >= 0; s--) begin
      en[s] = !vld_q[s] || en[s+1];
    end
  end

  assign s_axis_tready = en[0];
  assign s_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int s = 0; s < NumStages; s++) begin
        if (en[s]) begin
          vld_q[s] <= (s == 0) ? s_axis_tvalid : vld_q[(s == 0) ? 0 : s - 1];
        end
      end
    end
  end

  // blob phase steps after the last pixel of a frame
  always_comb begin
    phase_d = phase_q;
    if (s_fire && s_axis_tlast) begin
      phase_d = (phase_q >= PhaseW'(PhaseSteps - 1)) ? '0 : phase_q + PhaseW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  div_in_t  div_in;
  div_out_t div_out;

  gbpg_geom #(.MAX_DIM(MAX_DIM)) u_geom (
    .clk_i    (clk_i),
    .en_i     (en[GeoStages-1:0]),
    .px_i     (s_axis_tdata[11:0]),
    .py_i     (s_axis_tdata[23:12]),
    .last_i   (s_axis_tlast),
    .phase_i  (phase_q),
    .width_i  (width_q),
    .height_i (height_q),
    .div_o    (div_in)
  );

  gbpg_div u_div (
    .clk_i (clk_i),
    .en_i  (en[GeoStages+DivStages-1:GeoStages]),
    .div_i (div_in),
    .div_o (div_out)
  );

  gbpg_exp u_exp (
    .clk_i   (clk_i),
    .en_i    (en[NumStages-1:GeoStages+DivStages]),
    .div_i   (div_out),
    .value_o (m_axis_tdata),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tvalid = vld_q[NumStages-1];

  // phase never leaves its 60-step range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PhaseW'(PhaseSteps - 1))
    else $error("phase out of range");

  // an accepted beat lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> vld_q[0])
    else $error("accepted beat lost at entry");

  // a held output beat is not dropped inside the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

  // end of frame moves the blob
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tlast |=> phase_q != $past(phase_q))
    else $error("phase did not advance");

endmodule
